FILE: hw/rtl/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window maximum package
// Shared sizes, types and helper functions for the window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Capacity of the candidate queue and derived widths.
  localparam int WINDOW_MAX = 64;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 7;
  localparam int AW         = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int OCC_W      = $clog2(WINDOW_MAX + 1);
  localparam int POS_MOD    = 2 * WINDOW_MAX;
  localparam int PW         = $clog2(POS_MOD);
  localparam int AGE_W      = PW + 1;

  typedef logic [AW-1:0]    addr_t;
  typedef logic [OCC_W-1:0] occ_t;
  typedef logic [PW-1:0]    pos_t;
  typedef logic [CFG_W-1:0] win_t;
  typedef logic [AGE_W-1:0] age_t;
  typedef logic signed [DATA_W-1:0] sample_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;    // take in the accepted word
    logic rd_tail;  // read the entry just behind the tail
    logic pop;      // drop the back candidate
    logic push;     // write the new candidate at the tail
    logic rd_head;  // read the front candidate
    logic retire;   // deliver the result and age out the front
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic occ_zero;    // queue holds no candidate
    logic pop_hit;     // back candidate is smaller than the sample
    logic has_result;  // a full window will have arrived after the push
    logic out_free;    // result register can take a new word
  } dp_status_t;

  function automatic addr_t wrap_inc(input addr_t a);
    return (a == addr_t'(WINDOW_MAX - 1)) ? '0 : addr_t'(a + 1'b1);
  endfunction

  function automatic addr_t wrap_dec(input addr_t a);
    return (a == '0) ? addr_t'(WINDOW_MAX - 1) : addr_t'(a - 1'b1);
  endfunction

  function automatic pos_t pos_inc(input pos_t p);
    return (p == pos_t'(POS_MOD - 1)) ? '0 : pos_t'(p + 1'b1);
  endfunction

  // A size of zero acts as one; a size above the capacity acts as the capacity.
  function automatic win_t eff_window(input win_t w);
    if (w == '0) begin
      return win_t'(1);
    end else if (w > win_t'(WINDOW_MAX)) begin
      return win_t'(WINDOW_MAX);
    end
    return w;
  endfunction

endpackage : swm_pkg
`default_nettype wire

FILE: hw/rtl/swm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window maximum channels
// Valid/ready channels for samples, results and the window size register.
// ----------------------------------------------------------------------------

// Sample channel.
interface swm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic               start_of_sequence;

  modport source (output valid, output sample, output start_of_sequence, input ready);
  modport sink   (input valid, input sample, input start_of_sequence, output ready);
endinterface : swm_in_if

// Result channel.
interface swm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] window_max;

  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface : swm_out_if

// Window size write channel.
interface swm_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface : swm_cfg_if
`default_nettype wire

FILE: hw/rtl/swm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window maximum datapath
// Candidate memory, queue pointers, counters, window size and result register.
// ----------------------------------------------------------------------------
module swm_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire swm_pkg::ctrl_cmd_t cmd,
  output swm_pkg::dp_status_t     status,
  swm_in_if.sink                  in_ch,
  swm_out_if.source               out_ch,
  swm_cfg_if.sink                 cfg_ch
);
  import swm_pkg::*;

  // Candidate store: value and arrival position for each entry.
  sample_t mem_val [WINDOW_MAX];
  pos_t    mem_pos [WINDOW_MAX];

  sample_t samp_r;
  sample_t rd_val_r;
  pos_t    rd_pos_r;
  pos_t    now_r;
  addr_t   head_r, head_nxt;
  addr_t   tail_r, tail_nxt;
  occ_t    occ_r, occ_nxt;
  pos_t    pos_r, pos_nxt;
  win_t    seen_r, seen_nxt;
  win_t    ws_r;
  logic    out_valid_r;
  sample_t out_max_r;

  win_t    k;
  win_t    seen_inc;
  addr_t   rd_addr;
  logic    full;
  age_t    age;

  assign k = eff_window(ws_r);

  // Samples seen after this one, saturating at the window size.
  assign seen_inc = (seen_r < k) ? win_t'(seen_r + 1'b1) : seen_r;
  assign full     = (occ_r == occ_t'(WINDOW_MAX));

  // Age of the front candidate relative to the newest sample.
  always_comb begin
    if (now_r >= rd_pos_r) begin
      age = age_t'(now_r - rd_pos_r) + age_t'(1);
    end else begin
      age = age_t'(now_r) + age_t'(POS_MOD) - age_t'(rd_pos_r) + age_t'(1);
    end
  end

  // Status toward the controller.
  assign status.occ_zero   = (occ_r == '0);
  assign status.pop_hit    = (rd_val_r < samp_r);
  assign status.has_result = (seen_inc >= k);
  assign status.out_free   = !out_valid_r || out_ch.ready;

  // Memory port: one write, one registered read.
  assign rd_addr = cmd.rd_tail ? wrap_dec(tail_r) : head_r;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem_val[tail_r] <= samp_r;
      mem_pos[tail_r] <= pos_r;
    end
    if (cmd.rd_tail || cmd.rd_head) begin
      rd_val_r <= mem_val[rd_addr];
      rd_pos_r <= mem_pos[rd_addr];
    end
  end

  // Queue pointers and counters.
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt  = occ_r;
    pos_nxt  = pos_r;
    seen_nxt = seen_r;
    if (cmd.latch && in_ch.start_of_sequence) begin
      head_nxt = '0;
      tail_nxt = '0;
      occ_nxt  = '0;
      pos_nxt  = '0;
      seen_nxt = '0;
    end
    if (cmd.pop) begin
      tail_nxt = wrap_dec(tail_r);
      occ_nxt  = occ_t'(occ_r - 1'b1);
    end
    if (cmd.push) begin
      tail_nxt = wrap_inc(tail_r);
      pos_nxt  = pos_inc(pos_r);
      seen_nxt = seen_inc;
      if (full) begin
        head_nxt = wrap_inc(head_r);
      end else begin
        occ_nxt = occ_t'(occ_r + 1'b1);
      end
    end
    if (cmd.retire && (age >= age_t'(k))) begin
      head_nxt = wrap_inc(head_r);
      occ_nxt  = occ_t'(occ_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      pos_r       <= '0;
      seen_r      <= '0;
      ws_r        <= win_t'(1);
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
      pos_r  <= pos_nxt;
      seen_r <= seen_nxt;
      if (cfg_ch.valid) begin
        ws_r <= cfg_ch.window_size;
      end
      if (cmd.retire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      samp_r <= in_ch.sample;
    end
    if (cmd.push) begin
      now_r <= pos_r;
    end
    if (cmd.retire) begin
      out_max_r <= rd_val_r;
    end
  end

  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.window_max = out_max_r;

endmodule : swm_datapath
`default_nettype wire

FILE: hw/rtl/swm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window maximum controller
// Sequences the pops, the push and the front read for each accepted word.
// ----------------------------------------------------------------------------
module swm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire swm_pkg::dp_status_t status,
  output swm_pkg::ctrl_cmd_t       cmd
);
  import swm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_POP_CMP,
    S_PUSH,
    S_HEAD_RD,
    S_HEAD_CMP
  } state_t;

  state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_POP_RD;
        end
      end
      S_POP_RD: begin
        state_nxt = status.occ_zero ? S_PUSH : S_POP_CMP;
      end
      S_POP_CMP: begin
        state_nxt = status.pop_hit ? S_POP_RD : S_PUSH;
      end
      S_PUSH: begin
        state_nxt = status.has_result ? S_HEAD_RD : S_IDLE;
      end
      S_HEAD_RD: begin
        state_nxt = S_HEAD_CMP;
      end
      S_HEAD_CMP: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands decoded from the state.
  always_comb begin
    cmd         = '0;
    cmd.latch   = (state_r == S_IDLE) && in_valid;
    cmd.rd_tail = (state_r == S_POP_RD) && !status.occ_zero;
    cmd.pop     = (state_r == S_POP_CMP) && status.pop_hit;
    cmd.push    = (state_r == S_PUSH);
    cmd.rd_head = (state_r == S_HEAD_RD);
    cmd.retire  = (state_r == S_HEAD_CMP) && status.out_free;
  end

  assign in_ready = (state_r == S_IDLE);

endmodule : swm_ctrl
`default_nettype wire

FILE: hw/rtl/sliding_window_maximum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window maximum
// Running maximum of the last window_size signed samples of a sequence.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one sample word per handshake; start_of_sequence set on a
//   word empties the window before that sample is taken in. out_ch carries one
//   window_max word per sample once window_size samples of the sequence have
//   arrived; earlier samples give no word. cfg_ch is always ready. The user
//   must write window_size only while the block is idle; nothing enforces it.
//   Each sample passes through S_POP_RD and S_POP_CMP for every candidate
//   compared at the back of the queue (popped ones plus the one that stops
//   the search, if any), through S_POP_RD again when the queue is empty or
//   runs empty, and then through S_PUSH. A sample that gives a result goes on
//   through S_HEAD_RD and S_HEAD_CMP, and stays in S_HEAD_CMP while an
//   earlier word still waits in the output register. Each compare waits for
//   the registered read of the candidate memory. in_ch.ready is high only
//   between samples.
//   Reset empties the queue, clears the counters and sets window_size to 1.
//   A result waits in the output register; a new sample is accepted while it
//   waits, and the block holds the next result until out_ch.ready frees it.
// ----------------------------------------------------------------------------
module sliding_window_maximum (
  input  wire logic clk,
  input  wire logic rst_n,
  swm_in_if.sink    in_ch,
  swm_out_if.source out_ch,
  swm_cfg_if.sink   cfg_ch
);
  import swm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  // Sequencer.
  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Queue storage and arithmetic.
  swm_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .status (status),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  assign in_ch.ready = in_ready;

endmodule : sliding_window_maximum
`default_nettype wire

FILE: sim/tb_sliding_window_maximum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum testbench
// Drives sample words and window size writes into the block and checks every
// window_max word against a typed-in result or against a predictor with its
// own monotonic candidate queue. A short table of directed words comes first.
// Random runs of rising, falling, narrow and extreme samples follow, under
// several sender and receiver idling profiles and a range of window sizes.
// ----------------------------------------------------------------------------
module tb_sliding_window_maximum;

  import swm_pkg::*;

  localparam int CAND_DEPTH    = 64;
  localparam int SETTLE_CYCLES = 160;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DIRECTED_ROWS = 23;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 95;

  localparam sample_t S_MAX = 32'sh7FFF_FFFF;
  localparam sample_t S_MIN = 32'sh8000_0000;

  typedef enum int {RUN_FULL, RUN_NARROW, RUN_FALLING, RUN_RISING, RUN_EXTREME} run_kind_t;

  // One directed word: window size in force, the word, and a typed-in result.
  typedef struct packed {
    logic [6:0] win;
    sample_t    sample;
    logic       sos;
    logic       known;
    sample_t    result;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;

  swm_in_if  in_ch ();
  swm_out_if out_ch ();
  swm_cfg_if cfg_ch ();

  sliding_window_maximum dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: candidate queue, counters and the window size register.
  sample_t     cand_val [CAND_DEPTH];
  logic [6:0]  cand_pos [CAND_DEPTH];
  logic [5:0]  cand_head;
  logic [5:0]  cand_tail;
  int unsigned cand_count;
  logic [6:0]  seq_pos;
  int unsigned seq_seen;
  logic [6:0]  window_reg;

  sample_t       expected_max_q [$];
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  int            in_idle_pct    = 0;
  int            out_stall_pct  = 0;
  directed_row_t directed_rows [DIRECTED_ROWS];

  // Random stream state.
  run_kind_t run_kind;
  int        run_left = 0;
  sample_t   run_value;

  always #4 clk = ~clk;

  // Advances the predictor by one sample and gives the window maximum, if any.
  task automatic predict_window_max(input sample_t s, input logic sos,
                                    output bit has_max, output sample_t max_val);
    int unsigned span;
    logic [5:0]  back;
    logic [6:0]  now;
    logic [6:0]  age_gap;

    span = (window_reg == 7'd0) ? 1 : ((window_reg > 7'd64) ? 64 : window_reg);
    if (sos) begin
      cand_head  = '0;
      cand_tail  = '0;
      cand_count = 0;
      seq_pos    = '0;
      seq_seen   = 0;
    end

    // Smaller candidates at the back can never be the maximum again.
    while (cand_count > 0) begin
      back = cand_tail - 6'd1;
      if (cand_val[back] < s) begin
        cand_tail  = back;
        cand_count = cand_count - 1;
      end else begin
        break;
      end
    end
    if (cand_count >= CAND_DEPTH) begin
      cand_head  = cand_head + 6'd1;
      cand_count = cand_count - 1;
    end

    now                 = seq_pos;
    cand_val[cand_tail] = s;
    cand_pos[cand_tail] = now;
    cand_tail           = cand_tail + 6'd1;
    cand_count          = cand_count + 1;
    seq_pos             = seq_pos + 7'd1;

    if (seq_seen < span) seq_seen = seq_seen + 1;
    has_max = (seq_seen >= span);
    max_val = '0;
    if (has_max) begin
      max_val = cand_val[cand_head];
      // The front leaves once it is as old as the window, or older.
      age_gap = now - cand_pos[cand_head];
      if (age_gap + 1 >= span) begin
        cand_head  = cand_head + 6'd1;
        cand_count = cand_count - 1;
      end
    end
  endtask

  // Offers one sample word after a random gap and logs what it should produce.
  task automatic send_sample(input sample_t s, input logic sos,
                             input logic known, input sample_t typed);
    bit      has_max;
    sample_t max_val;

    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.sample            <= s;
    in_ch.start_of_sequence <= sos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_window_max(s, sos, has_max, max_val);
    if (known) begin
      expected_max_q.insert(expected_max_q.size(), typed);
    end else if (has_max) begin
      expected_max_q.insert(expected_max_q.size(), max_val);
    end
  endtask

  // Stops sending and waits until every result is in and the block is idle.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (expected_max_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [6:0] w);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.window_size <= w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    window_reg = w;
    cfg_ch.valid <= 1'b0;
  endtask

  // Random samples come in runs, so the queue both fills up and empties.
  task automatic next_stream_sample(output sample_t s);
    if (run_left == 0) begin
      run_kind  = run_kind_t'($urandom_range(4));
      run_left  = $urandom_range(1, 80);
      run_value = $urandom;
    end
    run_left = run_left - 1;
    case (run_kind)
      RUN_NARROW: begin
        s = $signed($urandom_range(8)) - 4;
      end
      RUN_FALLING: begin
        run_value = run_value - $signed($urandom_range(3));
        s = run_value;
      end
      RUN_RISING: begin
        run_value = run_value + $signed($urandom_range(3));
        s = run_value;
      end
      RUN_EXTREME: begin
        case ($urandom_range(3))
          0:       s = S_MAX;
          1:       s = S_MIN;
          2:       s = '0;
          default: s = -32'sd1;
        endcase
      end
      default: begin
        s = $urandom;
      end
    endcase
  endtask

  // Receiver side: random stalls on the result channel.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Every accepted result word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_max_q.size() == 0) begin
        $error("window_max: expected none, got %0d", out_ch.window_max);
        mismatch_count++;
      end else begin
        if (out_ch.window_max !== expected_max_q[0]) begin
          $error("window_max: expected %0d, got %0d", expected_max_q[0], out_ch.window_max);
          mismatch_count++;
        end
        expected_max_q.delete(0);
      end
    end
  end

  // Run time guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int         p;
    int         n;
    int         in_idle_set [4];
    int         out_stall_set [4];
    logic [6:0] phase_win [RANDOM_PHASES];
    sample_t    s;
    logic       sos;

    in_idle_set   = '{0, 76, 0, 13};
    out_stall_set = '{0, 0, 76, 13};
    phase_win     = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd5, 7'd0, 7'd33, 7'd2};
    phase_win[5]  = 7'($urandom_range(127));

    // Window 1 and 0 rows give the sample itself; the others go to the predictor.
    directed_rows = '{
      '{7'd1,   S_MAX,   1'b0, 1'b1, S_MAX},
      '{7'd1,   S_MIN,   1'b0, 1'b1, S_MIN},
      '{7'd1,   32'sd0,  1'b1, 1'b1, 32'sd0},
      '{7'd1,   -32'sd1, 1'b0, 1'b1, -32'sd1},
      '{7'd0,   32'sd1,  1'b0, 1'b1, 32'sd1},
      '{7'd0,   S_MIN,   1'b1, 1'b1, S_MIN},
      '{7'd3,   32'sd5,  1'b1, 1'b0, 32'sd0},
      '{7'd3,   32'sd2,  1'b0, 1'b0, 32'sd0},
      '{7'd3,   32'sd7,  1'b0, 1'b0, 32'sd0},
      '{7'd3,   32'sd7,  1'b0, 1'b0, 32'sd0},
      '{7'd3,   32'sd1,  1'b0, 1'b0, 32'sd0},
      '{7'd3,   32'sd0,  1'b0, 1'b0, 32'sd0},
      '{7'd3,   -32'sd5, 1'b0, 1'b0, 32'sd0},
      '{7'd5,   32'sd3,  1'b0, 1'b0, 32'sd0},
      '{7'd5,   32'sd4,  1'b0, 1'b0, 32'sd0},
      '{7'd5,   -32'sd8, 1'b0, 1'b0, 32'sd0},
      '{7'd2,   32'sd9,  1'b0, 1'b0, 32'sd0},
      '{7'd2,   32'sd2,  1'b0, 1'b0, 32'sd0},
      '{7'd2,   -32'sd3, 1'b1, 1'b0, 32'sd0},
      '{7'd2,   -32'sd4, 1'b0, 1'b0, 32'sd0},
      '{7'd127, S_MIN,   1'b1, 1'b0, 32'sd0},
      '{7'd127, S_MAX,   1'b0, 1'b0, 32'sd0},
      '{7'd64,  32'sd100, 1'b1, 1'b0, 32'sd0}
    };

    // Reset values of the predictor match the block after reset.
    cand_head  = '0;
    cand_tail  = '0;
    cand_count = 0;
    seq_pos    = '0;
    seq_seen   = 0;
    window_reg = 7'd1;

    rst_n                   <= 1'b0;
    in_ch.valid             <= 1'b0;
    in_ch.sample            <= '0;
    in_ch.start_of_sequence <= 1'b0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.window_size      <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words; the window size is rewritten whenever a row changes it.
    for (n = 0; n < DIRECTED_ROWS; n++) begin
      if (directed_rows[n].win != window_reg) begin
        settle_block();
        write_window(directed_rows[n].win);
      end
      send_sample(directed_rows[n].sample, directed_rows[n].sos,
                  directed_rows[n].known, directed_rows[n].result);
    end

    // Random phases; a new window size often lands in the middle of a sequence.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      settle_block();
      write_window(phase_win[p]);
      in_idle_pct   = in_idle_set[p % 4];
      out_stall_pct = out_stall_set[p % 4];
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (n == PHASE_WORDS / 2) begin
          // Sender holds off until every pending result has drained.
          in_ch.valid <= 1'b0;
          while (expected_max_q.size() != 0) @(posedge clk);
          @(posedge clk);
        end
        next_stream_sample(s);
        if (n == 0) begin
          sos = 1'($urandom_range(1));
        end else begin
          sos = ($urandom_range(99) < 2);
        end
        send_sample(s, sos, 1'b0, '0);
      end
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule : tb_sliding_window_maximum

FILE: filelist.f
hw/rtl/swm_pkg.sv
hw/rtl/swm_if.sv
hw/rtl/swm_datapath.sv
hw/rtl/swm_ctrl.sv
hw/rtl/sliding_window_maximum.sv
sim/tb_sliding_window_maximum.sv
